FILE: src/ifx_pkg.sv
// shared types and constants of the infix expression evaluator
package ifx_pkg;

	localparam logic [2:0] OP_PLUS   = 3'd0;
	localparam logic [2:0] OP_MINUS  = 3'd1;
	localparam logic [2:0] OP_TIMES  = 3'd2;
	localparam logic [2:0] OP_DIVIDE = 3'd3;
	localparam logic [2:0] OP_EQUALS = 3'd4;

	localparam logic CMD_NUMBER   = 1'b0;
	localparam logic CMD_OPERATOR = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DIVZ  = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;

	localparam int Q_DEPTH = 2;

	typedef enum logic [2:0] {
		TK_NUM,
		TK_ADD,
		TK_SUB,
		TK_MUL,
		TK_DIV,
		TK_EQ,
		TK_BAD
	} tok_kind_t;

	typedef enum logic [1:0] {
		MOP_NONE,
		MOP_TIMES,
		MOP_DIVIDE
	} mul_op_t;

	typedef enum logic {
		BK_FETCH,
		BK_WAIT
	} back_state_t;

	typedef enum logic [1:0] {
		MDU_IDLE,
		MDU_RUN,
		MDU_DONE
	} mdu_state_t;

	typedef struct packed {
		logic      valid;
		tok_kind_t kind;
	} tok_ctrl_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} mdu_req_t;

endpackage

FILE: src/ifx_front.sv
// token intake: classifies tokens and queues them for the evaluation side
module ifx_front #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_command,
	input  logic [DATA_WIDTH-1:0]   in_value,
	input  logic [2:0]              in_op,
	output ifx_pkg::tok_ctrl_t      tok,
	output logic [DATA_WIDTH-1:0]   tok_value,
	input  logic                    tok_pop
);

	localparam int PTR_W = (ifx_pkg::Q_DEPTH > 1) ? $clog2(ifx_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(ifx_pkg::Q_DEPTH + 1);

	ifx_pkg::tok_kind_t    kind_q [ifx_pkg::Q_DEPTH];
	logic [DATA_WIDTH-1:0] value_q [ifx_pkg::Q_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	ifx_pkg::tok_kind_t    in_kind;
	logic                  push;
	logic                  pop;

	always_comb begin
		if (in_command == ifx_pkg::CMD_NUMBER) begin
			in_kind = ifx_pkg::TK_NUM;
		end else begin
			case (in_op)
				ifx_pkg::OP_PLUS:   in_kind = ifx_pkg::TK_ADD;
				ifx_pkg::OP_MINUS:  in_kind = ifx_pkg::TK_SUB;
				ifx_pkg::OP_TIMES:  in_kind = ifx_pkg::TK_MUL;
				ifx_pkg::OP_DIVIDE: in_kind = ifx_pkg::TK_DIV;
				ifx_pkg::OP_EQUALS: in_kind = ifx_pkg::TK_EQ;
				default:            in_kind = ifx_pkg::TK_BAD;
			endcase
		end
	end

	assign in_ready  = (count_q != CNT_W'(ifx_pkg::Q_DEPTH));
	assign push      = in_valid && in_ready;
	assign pop       = tok_pop && tok.valid;
	assign tok.valid = (count_q != '0);
	assign tok.kind  = kind_q[rd_ptr_q];
	assign tok_value = value_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q]  <= in_kind;
			value_q[wr_ptr_q] <= in_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(ifx_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(ifx_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/ifx_mdu.sv
// iterative multiplier and truncating signed divider, one bit per cycle
module ifx_mdu #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ifx_pkg::mdu_req_t     req,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] result
);

	localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	ifx_pkg::mdu_state_t   state_q;
	ifx_pkg::mdu_state_t   state_d;
	logic [CNT_W-1:0]      cnt_q;
	logic                  is_div_q;
	logic                  neg_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] sh_q;
	logic [DATA_WIDTH-1:0] op_q;
	logic [DATA_WIDTH:0]   rem_sh;
	logic [DATA_WIDTH:0]   diff;
	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;
	logic                  last_step;

	assign mag_a     = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
	assign mag_b     = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
	assign rem_sh    = {acc_q, sh_q[DATA_WIDTH-1]};
	assign diff      = rem_sh - {1'b0, op_q};
	assign last_step = (cnt_q == CNT_W'(DATA_WIDTH - 1));

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			ifx_pkg::MDU_IDLE: begin
				if (req.start) state_d = ifx_pkg::MDU_RUN;
			end
			ifx_pkg::MDU_RUN: begin
				if (last_step) state_d = ifx_pkg::MDU_DONE;
			end
			ifx_pkg::MDU_DONE: begin
				done    = 1'b1;
				state_d = ifx_pkg::MDU_IDLE;
			end
			default: state_d = ifx_pkg::MDU_IDLE;
		endcase
	end

	always_comb begin
		if (is_div_q) begin
			result = neg_q ? (~sh_q + 1'b1) : sh_q;
		end else begin
			result = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ifx_pkg::MDU_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ifx_pkg::MDU_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ifx_pkg::MDU_IDLE && req.start) begin
			is_div_q <= req.is_div;
			acc_q    <= '0;
			if (req.is_div) begin
				neg_q <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
				sh_q  <= mag_a;
				op_q  <= mag_b;
			end else begin
				neg_q <= 1'b0;
				sh_q  <= b;
				op_q  <= a;
			end
		end else if (state_q == ifx_pkg::MDU_RUN) begin
			if (is_div_q) begin
				sh_q <= {sh_q[DATA_WIDTH-2:0], !diff[DATA_WIDTH]};
				acc_q <= diff[DATA_WIDTH] ? rem_sh[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
			end else begin
				if (sh_q[0]) acc_q <= acc_q + op_q;
				op_q <= {op_q[DATA_WIDTH-2:0], 1'b0};
				sh_q <= {1'b0, sh_q[DATA_WIDTH-1:1]};
			end
		end
	end

endmodule

FILE: src/ifx_back.sv
// evaluation side: precedence state, arithmetic sequencing and result register
module ifx_back #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ifx_pkg::tok_ctrl_t    tok,
	input  logic [DATA_WIDTH-1:0] tok_value,
	output logic                  tok_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] out_value,
	output logic [1:0]            out_status
);

	ifx_pkg::back_state_t  state_q;
	ifx_pkg::back_state_t  state_d;
	logic [DATA_WIDTH-1:0] sum_q;
	logic [DATA_WIDTH-1:0] term_q;
	logic                  minus_q;
	ifx_pkg::mul_op_t      mop_q;
	logic                  expect_q;
	logic [1:0]            err_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_value_q;
	logic [1:0]            out_status_q;
	logic [DATA_WIDTH-1:0] fold;
	logic [1:0]            err_order;
	logic                  out_free;
	logic                  div_zero;
	ifx_pkg::mdu_req_t     mdu_req;
	logic                  mdu_done;
	logic [DATA_WIDTH-1:0] mdu_result;

	ifx_mdu #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mdu_req),
		.a      (term_q),
		.b      (tok_value),
		.done   (mdu_done),
		.result (mdu_result)
	);

	assign fold      = minus_q ? (sum_q - term_q) : (sum_q + term_q);
	assign err_order = (err_q == ifx_pkg::ST_OK) ? ifx_pkg::ST_ORDER : err_q;
	assign out_free  = !out_valid_q || out_ready;
	assign div_zero  = (mop_q == ifx_pkg::MOP_DIVIDE) && (tok_value == '0);

	always_comb begin
		state_d        = state_q;
		tok_pop        = 1'b0;
		mdu_req.start  = 1'b0;
		mdu_req.is_div = (mop_q == ifx_pkg::MOP_DIVIDE);
		case (state_q)
			ifx_pkg::BK_FETCH: begin
				if (tok.valid && (tok.kind != ifx_pkg::TK_EQ || out_free)) begin
					tok_pop = 1'b1;
					if (tok.kind == ifx_pkg::TK_NUM && expect_q &&
					    mop_q != ifx_pkg::MOP_NONE && !div_zero) begin
						mdu_req.start = 1'b1;
						state_d       = ifx_pkg::BK_WAIT;
					end
				end
			end
			ifx_pkg::BK_WAIT: begin
				if (mdu_done) state_d = ifx_pkg::BK_FETCH;
			end
			default: state_d = ifx_pkg::BK_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ifx_pkg::BK_FETCH;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			term_q      <= '0;
			minus_q     <= 1'b0;
			mop_q       <= ifx_pkg::MOP_NONE;
			expect_q    <= 1'b1;
			err_q       <= ifx_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (tok_pop && tok.kind == ifx_pkg::TK_EQ) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (mdu_done) begin
				term_q   <= mdu_result;
				expect_q <= 1'b0;
			end
			if (tok_pop) begin
				case (tok.kind)
					ifx_pkg::TK_NUM: begin
						if (!expect_q) begin
							err_q <= err_order;
						end else if (mop_q == ifx_pkg::MOP_NONE) begin
							term_q   <= tok_value;
							expect_q <= 1'b0;
						end else if (div_zero) begin
							term_q   <= '0;
							expect_q <= 1'b0;
							if (err_q == ifx_pkg::ST_OK) err_q <= ifx_pkg::ST_DIVZ;
						end
					end
					ifx_pkg::TK_ADD, ifx_pkg::TK_SUB: begin
						if (expect_q) begin
							err_q <= err_order;
						end else begin
							sum_q    <= fold;
							minus_q  <= (tok.kind == ifx_pkg::TK_SUB);
							term_q   <= '0;
							mop_q    <= ifx_pkg::MOP_NONE;
							expect_q <= 1'b1;
						end
					end
					ifx_pkg::TK_MUL, ifx_pkg::TK_DIV: begin
						if (expect_q) begin
							err_q <= err_order;
						end else begin
							mop_q    <= (tok.kind == ifx_pkg::TK_MUL) ?
							            ifx_pkg::MOP_TIMES : ifx_pkg::MOP_DIVIDE;
							expect_q <= 1'b1;
						end
					end
					ifx_pkg::TK_EQ: begin
						sum_q       <= '0;
						term_q      <= '0;
						minus_q     <= 1'b0;
						mop_q       <= ifx_pkg::MOP_NONE;
						expect_q    <= 1'b1;
						err_q       <= ifx_pkg::ST_OK;
					end
					default: begin
						err_q <= err_order;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop && tok.kind == ifx_pkg::TK_EQ) begin
			out_value_q  <= fold;
			out_status_q <= expect_q ? err_order : err_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;

	a_result_from_equals: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(tok_pop && tok.kind == ifx_pkg::TK_EQ))
		else $error("result raised without equals transaction");

	a_done_while_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_done |-> state_q == ifx_pkg::BK_WAIT)
		else $error("arithmetic unit finished outside wait state");

	a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ifx_pkg::BK_WAIT |-> !tok_pop)
		else $error("token taken while arithmetic unit busy");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ifx_pkg::ST_OK && !(tok_pop && tok.kind == ifx_pkg::TK_EQ))
		|=> $stable(err_q))
		else $error("sticky error changed before equals");

endmodule

FILE: src/infix_expression_evaluator.sv
// top level of the infix expression evaluator
//
// Tokens arrive on the s_axis channel, one per transaction: tuser says number
// or operator, tdata carries the operand and the operator code. Tokens must
// alternate number, operator and end with equals; times and divide bind
// tighter than plus and minus, and arithmetic wraps at DATA_WIDTH bits.
// Each equals token produces one transaction on m_axis with the value and a
// status (ok, division by zero, token out of order); the first error sticks.
// A two-entry token queue sits in front of the evaluation logic. A number
// that follows times or divide occupies the shared shift-add / restoring
// divide unit, and no further token is taken from the queue until that
// unit is done. The result is registered in the output register when
// equals is taken from the head of the queue. While m_axis_tready is low a
// finished result waits in that register and further tokens keep being
// evaluated; only the next equals waits. arst_n clears the queue, the
// output valid flag and the expression state.
module infix_expression_evaluator #(
	parameter  int DATA_WIDTH = 32,
	localparam int IN_W       = ((DATA_WIDTH + 3 + 7) / 8) * 8,
	localparam int OUT_W      = ((DATA_WIDTH + 2 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // number_value, operator_code, zero pad
	input  logic             s_axis_tuser,  // command
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // expression_value, status, zero pad
);

	ifx_pkg::tok_ctrl_t    tok;
	logic [DATA_WIDTH-1:0] tok_value;
	logic                  tok_pop;
	logic [DATA_WIDTH-1:0] out_value;
	logic [1:0]            out_status;

	ifx_front #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_command (s_axis_tuser),
		.in_value   (s_axis_tdata[DATA_WIDTH-1:0]),
		.in_op      (s_axis_tdata[DATA_WIDTH+2:DATA_WIDTH]),
		.tok        (tok),
		.tok_value  (tok_value),
		.tok_pop    (tok_pop)
	);

	ifx_back #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok        (tok),
		.tok_value  (tok_value),
		.tok_pop    (tok_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_value  (out_value),
		.out_status (out_status)
	);

	assign m_axis_tdata = OUT_W'({out_status, out_value});

endmodule
